/* hw/rtl/sps_pkg.sv */
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the setpoint smoother
// Register map, fixed widths, controller/datapath command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  localparam int unsigned PosWidthDef = 32;
  localparam int unsigned AngWidthDef = 16;
  localparam int unsigned VelW        = 32;
  localparam int unsigned DtW         = 16;
  localparam int unsigned LimW        = 31;
  localparam int unsigned RateW       = 23;
  localparam int unsigned ProdW       = LimW + DtW;
  localparam int unsigned DtMax       = 32768;
  localparam int unsigned TauFloor    = 66;
  localparam int unsigned SnapTol     = 6;
  localparam int unsigned BigErrShift = 47;
  localparam int unsigned AddrW       = 5;

  typedef enum logic [2:0] {
    REG_TAU  = 3'd0,
    REG_HSPD = 3'd1,
    REG_VSPD = 3'd2,
    REG_HACC = 3'd3,
    REG_VACC = 3'd4,
    REG_RATE = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [LimW-1:0]  tau;
    logic [LimW-1:0]  hspd;
    logic [LimW-1:0]  vspd;
    logic [LimW-1:0]  hacc;
    logic [LimW-1:0]  vacc;
    logic [RateW-1:0] rate;
  } cfg_t;

  typedef struct packed {
    logic       latch;
    logic       init;
    logic       hold;
    logic       load;
    logic       div_step;
    logic       lim;
    logic       vel;
    logic       mulv;
    logic       pos;
    logic       hdg_mul;
    logic       hdg_upd;
    logic       load_out;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic out_free;
  } sts_t;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_DISP = 12'b0000_0000_0010,
    S_INIT = 12'b0000_0000_0100,
    S_HOLD = 12'b0000_0000_1000,
    S_LOAD = 12'b0000_0001_0000,
    S_DIV  = 12'b0000_0010_0000,
    S_LIM  = 12'b0000_0100_0000,
    S_VEL  = 12'b0000_1000_0000,
    S_MULV = 12'b0001_0000_0000,
    S_POS  = 12'b0010_0000_0000,
    S_HMUL = 12'b0100_0000_0000,
    S_HUPD = 12'b1000_0000_0000
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/sps_in_if.sv */
// ----------------------------------------------------------------------------
// sps_in_if: goal request channel
// Valid/ready channel carrying goal position, heading and step time.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_in_if
  import sps_pkg::*;
#(
  parameter int unsigned PosW = PosWidthDef,
  parameter int unsigned AngW = AngWidthDef
);
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] goal_x;
  logic signed [PosW-1:0] goal_y;
  logic signed [PosW-1:0] goal_z;
  logic signed [AngW-1:0] goal_heading;
  logic [DtW-1:0]         step_time;

  modport source (output valid, goal_x, goal_y, goal_z, goal_heading, step_time,
                  input ready);
  modport sink   (input valid, goal_x, goal_y, goal_z, goal_heading, step_time,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/sps_out_if.sv */
// ----------------------------------------------------------------------------
// sps_out_if: smoothed setpoint channel
// Valid/ready channel carrying target position, heading and velocity.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_out_if
  import sps_pkg::*;
#(
  parameter int unsigned PosW = PosWidthDef,
  parameter int unsigned AngW = AngWidthDef
);
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] out_x;
  logic signed [PosW-1:0] out_y;
  logic signed [PosW-1:0] out_z;
  logic signed [AngW-1:0] out_heading;
  logic signed [VelW-1:0] out_vx;
  logic signed [VelW-1:0] out_vy;
  logic signed [VelW-1:0] out_vz;

  modport source (output valid, out_x, out_y, out_z, out_heading, out_vx, out_vy,
                  out_vz, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_heading, out_vx, out_vy,
                  out_vz, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sps_ctrl.sv */
// ----------------------------------------------------------------------------
// sps_ctrl: sequencer of the setpoint smoother
// One-hot FSM stepping the datapath through the axes and the heading.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_ctrl
  import sps_pkg::*;
#(
  parameter int unsigned DivBits = 49
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam int unsigned CntW = $clog2(DivBits + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      axis_q, axis_d;
  logic            started_q, started_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    axis_d    = axis_q;
    started_d = started_q;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        axis_d = 2'd0;
        if (!started_q) state_d = S_INIT;
        else if (sts_i.dt_zero) state_d = S_HOLD;
        else state_d = S_LOAD;
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        started_d  = 1'b1;
        state_d    = S_HUPD;
      end
      S_HOLD: begin
        cmd_o.hold = 1'b1;
        state_d    = S_HUPD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivBits - 1)) state_d = S_LIM;
      end
      S_LIM: begin
        cmd_o.lim = 1'b1;
        state_d   = S_VEL;
      end
      S_VEL: begin
        cmd_o.vel = 1'b1;
        state_d   = S_MULV;
      end
      S_MULV: begin
        cmd_o.mulv = 1'b1;
        state_d    = S_POS;
      end
      S_POS: begin
        cmd_o.pos = 1'b1;
        if (axis_q == 2'd2) begin
          cnt_d   = '0;
          state_d = S_HMUL;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_LOAD;
        end
      end
      S_HMUL: begin
        // rate multiply, then heading update
        if (cnt_q == '0) begin
          cmd_o.hdg_mul = 1'b1;
          cnt_d         = CntW'(1);
        end else begin
          cmd_o.hdg_upd = 1'b1;
          state_d       = S_HUPD;
        end
      end
      S_HUPD: begin
        // result hand-off, shared by init, hold and moving requests
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      axis_q    <= 2'd0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      axis_q    <= axis_d;
      started_q <= started_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sps_dp.sv */
// ----------------------------------------------------------------------------
// sps_dp: datapath of the setpoint smoother
// Axis state, bit-serial divider, shared multiplier and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_dp
  import sps_pkg::*;
#(
  parameter int unsigned PosW = PosWidthDef,
  parameter int unsigned AngW = AngWidthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cmd_t                   cmd_i,
  output sts_t                        sts_o,
  input  wire cfg_t                   cfg_i,
  input  wire logic signed [PosW-1:0] goal_x_i,
  input  wire logic signed [PosW-1:0] goal_y_i,
  input  wire logic signed [PosW-1:0] goal_z_i,
  input  wire logic signed [AngW-1:0] goal_heading_i,
  input  wire logic [DtW-1:0]         step_time_i,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output logic signed [PosW-1:0]      out_pos_o [3],
  output logic signed [VelW-1:0]      out_vel_o [3],
  output logic signed [AngW-1:0]      out_heading_o
);

  localparam int unsigned DivW = PosW + 17;
  localparam int unsigned SumW = ((PosW > VelW) ? PosW : VelW) + 2;
  localparam int unsigned HdgW = ((AngW > RateW) ? AngW : RateW) + 2;
  localparam logic signed [SumW-1:0] PosMax =
      $signed((SumW'(1) << (PosW - 1)) - SumW'(1));
  localparam logic signed [SumW-1:0] PosMin = -PosMax - SumW'(1);
  localparam logic signed [SumW-1:0] Tol    = SumW'(SnapTol);

  logic signed [PosW-1:0] goal_q [3];
  logic signed [PosW-1:0] pos_q [3];
  logic signed [VelW-1:0] vel_q [3];
  logic signed [AngW-1:0] hdg_q, gh_q;
  logic [DtW-1:0]         dt_q;
  logic [LimW-1:0]        den_q;
  logic [DivW-1:0]        quo_q;
  logic [LimW-1:0]        rem_q;
  logic                   neg_q, big_q, e0z_q;
  logic signed [VelW-1:0] q_q, vn_q;
  logic [ProdW-1:0]       prod_q;
  logic                   out_valid_q;
  logic signed [PosW-1:0] opos_q [3];
  logic signed [VelW-1:0] ovel_q [3];
  logic signed [AngW-1:0] ohdg_q;

  logic [DtW-1:0]         dtc;
  logic [LimW-1:0]        tauf;
  logic [LimW-1:0]        spd, acc;
  logic signed [PosW:0]   e0;
  logic [PosW:0]          emag;
  logic [31:0]            rem_sh;
  logic                   ge;
  logic [LimW-1:0]        qmag;
  logic [LimW-1:0]        mul_a;
  logic signed [33:0]     qx, vx, ax, sx, diff, dv, vs, vn;
  logic [LimW-1:0]        vmag, sm;
  logic signed [SumW-1:0] sd, px, gx, nraw, ns, e1;
  logic                   crossed, snap;
  logic signed [AngW-1:0] hdiff;
  logic signed [HdgW-1:0] hx, stx, dlt;

  assign dtc  = (step_time_i > DtW'(DtMax)) ? DtW'(DtMax) : step_time_i;
  assign tauf = (cfg_i.tau < LimW'(TauFloor)) ? LimW'(TauFloor) : cfg_i.tau;
  assign spd  = (cmd_i.axis == 2'd2) ? cfg_i.vspd : cfg_i.hspd;
  assign acc  = (cmd_i.axis == 2'd2) ? cfg_i.vacc : cfg_i.hacc;

  assign e0   = (PosW+1)'(goal_q[cmd_i.axis]) - (PosW+1)'(pos_q[cmd_i.axis]);
  assign emag = e0[PosW] ? (PosW+1)'(-e0) : (PosW+1)'(e0);

  assign rem_sh = {rem_q, quo_q[DivW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  assign qmag = big_q ? spd : ((quo_q > DivW'(spd)) ? spd : quo_q[LimW-1:0]);

  assign vmag = vn_q[VelW-1] ? LimW'(-vn_q) : vn_q[LimW-1:0];
  always_comb begin
    mul_a = vmag;
    if (cmd_i.lim) mul_a = acc;
    else if (cmd_i.hdg_mul) mul_a = LimW'(cfg_i.rate);
  end

  always_comb begin
    qx   = 34'(q_q);
    vx   = 34'(vel_q[cmd_i.axis]);
    ax   = $signed({3'b000, prod_q[ProdW-1:DtW]});
    sx   = $signed({3'b000, spd});
    diff = qx - vx;
    if (diff > ax) dv = ax;
    else if (diff < -ax) dv = -ax;
    else dv = diff;
    vs = vx + dv;
    if (vs > sx) vn = sx;
    else if (vs < -sx) vn = -sx;
    else vn = vs;
  end

  always_comb begin
    sm   = prod_q[ProdW-1:DtW];
    sd   = vn_q[VelW-1] ? -$signed(SumW'(sm)) : $signed(SumW'(sm));
    px   = SumW'(pos_q[cmd_i.axis]);
    gx   = SumW'(goal_q[cmd_i.axis]);
    nraw = px + sd;
    if (nraw > PosMax) ns = PosMax;
    else if (nraw < PosMin) ns = PosMin;
    else ns = nraw;
    e1      = gx - ns;
    crossed = e0z_q || (e1 == '0) || (neg_q != e1[SumW-1]);
    snap    = crossed || ((e1 <= Tol) && (e1 >= -Tol));
  end

  always_comb begin
    hdiff = gh_q - hdg_q;
    hx    = HdgW'(hdiff);
    stx   = $signed(HdgW'(prod_q[RateW+DtW-1:DtW]));
    if (hx > stx) dlt = stx;
    else if (hx < -stx) dlt = -stx;
    else dlt = hx;
  end

  assign sts_o.dt_zero  = (dt_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      goal_q[0] <= goal_x_i;
      goal_q[1] <= goal_y_i;
      goal_q[2] <= goal_z_i;
      gh_q      <= goal_heading_i;
      dt_q      <= dtc;
      den_q     <= (tauf > LimW'(dtc)) ? tauf : LimW'(dtc);
    end
    if (cmd_i.load) begin
      quo_q <= {emag, 16'h0000};
      rem_q <= '0;
      neg_q <= e0[PosW];
      e0z_q <= (e0 == '0);
      big_q <= 64'(emag) >= (64'(1) << BigErrShift);
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? LimW'(rem_sh - {1'b0, den_q}) : rem_sh[LimW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
    if (cmd_i.lim) q_q <= neg_q ? -VelW'(qmag) : VelW'(qmag);
    if (cmd_i.lim || cmd_i.mulv || cmd_i.hdg_mul) prod_q <= ProdW'(mul_a) * ProdW'(dt_q);
    if (cmd_i.vel) vn_q <= vn[VelW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        pos_q[k] <= '0;
        vel_q[k] <= '0;
      end
      hdg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.init) begin
        pos_q <= goal_q;
        for (int k = 0; k < 3; k++) vel_q[k] <= '0;
        hdg_q <= gh_q;
      end
      if (cmd_i.hold) hdg_q <= gh_q;
      if (cmd_i.pos) begin
        pos_q[cmd_i.axis] <= snap ? goal_q[cmd_i.axis] : ns[PosW-1:0];
        vel_q[cmd_i.axis] <= snap ? '0 : vn_q;
      end
      if (cmd_i.hdg_upd) hdg_q <= AngW'(hdg_q + dlt[AngW-1:0]);
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      opos_q <= pos_q;
      ovel_q <= vel_q;
      ohdg_q <= hdg_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_pos_o     = opos_q;
  assign out_vel_o     = ovel_q;
  assign out_heading_o = ohdg_q;

endmodule

`default_nettype wire

/* hw/rtl/setpoint_smoother_axes_yaw_top.sv */
// ----------------------------------------------------------------------------
// setpoint_smoother_axes_yaw_top: rate and acceleration limited setpoint ramp
//
// Channels: in_i takes a goal request (x, y, z, heading, step time); out_o
// returns one smoothed setpoint (position, heading, velocity) per request.
// Both use valid/ready; a request is taken when valid and ready are high.
// Limits and time constant are set through the APB port; the user must write
// them only while idle, which the block does not enforce. A moving request
// uses the divider, one quotient bit per cycle and shared by the three axes,
// for each axis in turn; the first request after reset and zero-step requests
// skip it. One request is worked on at a time; the next is taken once the
// result is in the output register.
// Reset clears the axis state, the configuration to its defaults and drops
// any pending result. A stalled receiver holds the result; the block then
// finishes at most the next request and waits.
// ----------------------------------------------------------------------------
`default_nettype none

module setpoint_smoother_axes_yaw_top
  import sps_pkg::*;
#(
  parameter int unsigned POS_WIDTH = PosWidthDef,
  parameter int unsigned ANG_WIDTH = AngWidthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  sps_in_if.sink            in_i,
  sps_out_if.source         out_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic wr_en;
  logic [2:0] ridx;

  logic signed [POS_WIDTH-1:0] out_pos [3];
  logic signed [VelW-1:0]      out_vel [3];

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tau  <= LimW'(65536);
      cfg_q.hspd <= LimW'(131072);
      cfg_q.vspd <= LimW'(65536);
      cfg_q.hacc <= LimW'(65536);
      cfg_q.vacc <= LimW'(65536);
      cfg_q.rate <= RateW'(32768);
    end else if (wr_en) begin
      case (ridx)
        REG_TAU:  cfg_q.tau  <= pwdata[LimW-1:0];
        REG_HSPD: cfg_q.hspd <= pwdata[LimW-1:0];
        REG_VSPD: cfg_q.vspd <= pwdata[LimW-1:0];
        REG_HACC: cfg_q.hacc <= pwdata[LimW-1:0];
        REG_VACC: cfg_q.vacc <= pwdata[LimW-1:0];
        REG_RATE: cfg_q.rate <= pwdata[RateW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_TAU:  prdata = {1'b0, cfg_q.tau};
      REG_HSPD: prdata = {1'b0, cfg_q.hspd};
      REG_VSPD: prdata = {1'b0, cfg_q.vspd};
      REG_HACC: prdata = {1'b0, cfg_q.hacc};
      REG_VACC: prdata = {1'b0, cfg_q.vacc};
      REG_RATE: prdata = {9'd0, cfg_q.rate};
      default:  prdata = '0;
    endcase
  end

  sps_ctrl #(
    .DivBits(POS_WIDTH + 17)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  sps_dp #(
    .PosW(POS_WIDTH),
    .AngW(ANG_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_i         (cfg_q),
    .goal_x_i      (in_i.goal_x),
    .goal_y_i      (in_i.goal_y),
    .goal_z_i      (in_i.goal_z),
    .goal_heading_i(in_i.goal_heading),
    .step_time_i   (in_i.step_time),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_pos_o     (out_pos),
    .out_vel_o     (out_vel),
    .out_heading_o (out_o.out_heading)
  );

  assign out_o.out_x  = out_pos[0];
  assign out_o.out_y  = out_pos[1];
  assign out_o.out_z  = out_pos[2];
  assign out_o.out_vx = out_vel[0];
  assign out_o.out_vy = out_vel[1];
  assign out_o.out_vz = out_vel[2];

`ifndef SYNTHESIS
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request taken while busy");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result without a request in flight");
`endif

endmodule

`default_nettype wire
